### sv/asp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the slope percent unit
// Holds the result format, the percent scale factor and the control word that
// travels with every sample through the cell chains.
// ----------------------------------------------------------------------------
package asp_pkg;

   // Result format: unsigned fixed point, saturating at all ones.
   localparam int unsigned SLOPE_BITS = 24;
   localparam logic [SLOPE_BITS-1:0] SLOPE_MAX = '1;

   // The slope is the tangent times 100, so the squared sum is scaled by 100^2.
   localparam int unsigned SCALE_BITS = 14;
   localparam logic [SCALE_BITS-1:0] SCALE_PCT_SQ = 14'd10000;

   // Control word that moves along the pipeline next to each sample.
   typedef struct packed {
      logic valid;
      logic invalid;
      logic saturated;
   } asp_ctrl_type;

endpackage : asp_pkg
`default_nettype wire

### sv/asp_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_sqrt_cell: one step of the restoring square root chain
// Brings down the next two radicand bits, tries the next root bit and hands
// the partial remainder, partial root and the sample sideband to its neighbor.
// ----------------------------------------------------------------------------
module asp_sqrt_cell #(
   parameter int unsigned RAD_BITS  = 62,
   parameter int unsigned ROOT_BITS = 31,
   parameter int unsigned AZ_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire asp_pkg::asp_ctrl_type ctrl_in,
   input  wire logic [RAD_BITS-1:0]   rad_in,
   input  wire logic [ROOT_BITS+1:0]  rem_in,
   input  wire logic [ROOT_BITS-1:0]  root_in,
   input  wire logic [AZ_BITS-1:0]    az_in,
   output asp_pkg::asp_ctrl_type      ctrl_out,
   output logic      [RAD_BITS-1:0]   rad_out,
   output logic      [ROOT_BITS+1:0]  rem_out,
   output logic      [ROOT_BITS-1:0]  root_out,
   output logic      [AZ_BITS-1:0]    az_out
);
   import asp_pkg::*;

   asp_ctrl_type           ctrl_ff;
   logic [RAD_BITS-1:0]    rad_ff;
   logic [ROOT_BITS+1:0]   rem_ff;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [AZ_BITS-1:0]     az_ff;

   logic [ROOT_BITS+1:0]   rem_shift;
   logic [ROOT_BITS+1:0]   trial;
   logic                   fits;
   logic [RAD_BITS-1:0]    rad_in_nx;
   logic [ROOT_BITS+1:0]   rem_in_nx;
   logic [ROOT_BITS-1:0]   root_in_nx;

   // The remainder never exceeds twice the partial root, so its top two bits
   // are zero before the shift.
   always_comb begin
      rem_shift  = {rem_in[ROOT_BITS-1:0], rad_in[RAD_BITS-1 -: 2]};
      trial      = {root_in, 2'b01};
      fits       = (rem_shift >= trial);
      rem_in_nx  = fits ? (rem_shift - trial) : rem_shift;
      root_in_nx = {root_in[ROOT_BITS-2:0], fits};
      rad_in_nx  = {rad_in[RAD_BITS-3:0], 2'b00};
   end

   // Control word, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in_nx;
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         az_ff   <= az_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign az_out   = az_ff;

endmodule : asp_sqrt_cell
`default_nettype wire

### sv/asp_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asp_div_cell: one step of the restoring division chain
// Shifts the next numerator bit into the partial remainder, subtracts |z| when
// it fits and shifts the new quotient bit into the numerator/quotient word.
// ----------------------------------------------------------------------------
module asp_div_cell #(
   parameter int unsigned AZ_BITS  = 16,
   parameter int unsigned QUO_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire asp_pkg::asp_ctrl_type ctrl_in,
   input  wire logic [AZ_BITS:0]      rem_in,
   input  wire logic [QUO_BITS-1:0]   nq_in,
   input  wire logic [AZ_BITS-1:0]    az_in,
   output asp_pkg::asp_ctrl_type      ctrl_out,
   output logic      [AZ_BITS:0]      rem_out,
   output logic      [QUO_BITS-1:0]   nq_out,
   output logic      [AZ_BITS-1:0]    az_out
);
   import asp_pkg::*;

   asp_ctrl_type          ctrl_ff;
   logic [AZ_BITS:0]      rem_ff;
   logic [QUO_BITS-1:0]   nq_ff;
   logic [AZ_BITS-1:0]    az_ff;

   logic [AZ_BITS:0]      rem_shift;
   logic                  fits;
   logic [AZ_BITS:0]      rem_in_nx;
   logic [QUO_BITS-1:0]   nq_in_nx;

   // The remainder stays below |z|, so dropping its top bit loses nothing.
   always_comb begin
      rem_shift = {rem_in[AZ_BITS-1:0], nq_in[QUO_BITS-1]};
      fits      = (rem_shift >= {1'b0, az_in});
      rem_in_nx = fits ? (rem_shift - {1'b0, az_in}) : rem_shift;
      nq_in_nx  = {nq_in[QUO_BITS-2:0], fits};
   end

   // Control word, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_nx;
         nq_ff  <= nq_in_nx;
         az_ff  <= az_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign nq_out   = nq_ff;
   assign az_out   = az_ff;

endmodule : asp_div_cell
`default_nettype wire

### sv/accel_slope_percent_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accel_slope_percent_unit: slope of a three-axis accelerometer sample
// Returns 100 * sqrt(x^2 + y^2) / |z| as unsigned fixed point with
// FRACTION_BITS fraction bits, truncated and saturating at full scale.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one sample per beat (signed x, y and z counts).
//   The rsp_ channel returns exactly one result beat per sample, in order:
//   the slope, a saturated flag (clipped to full scale, also when z is zero)
//   and an invalid flag (all axes zero, slope reads zero).
//   A beat is taken when valid is high and stall is low.
//   Throughput is one sample per cycle while req_stall is low. A sample
//   passes through two front stages for the squares and the scaling, one
//   square root cell per root bit, one divider cell per result bit and
//   the output register.
//   When the receiver stalls, the output register holds its beat and one
//   more result drops into a skid register; only while that skid register
//   is full does the whole pipeline hold and req_stall rise.
//   A synchronous reset empties the pipeline, the output and the skid
//   register; no result is produced for samples in flight.
// ----------------------------------------------------------------------------
module accel_slope_percent_unit #(
   parameter int unsigned SAMPLE_BITS   = 16,
   parameter int unsigned FRACTION_BITS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Sample channel.
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_accel_x,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_accel_y,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_accel_z,
   // Result channel.
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [asp_pkg::SLOPE_BITS-1:0]      rsp_slope_pct_q8,
   output logic                                rsp_saturated,
   output logic                                rsp_invalid
);
   import asp_pkg::*;

   localparam int unsigned SQ_BITS   = 2 * SAMPLE_BITS;
   localparam int unsigned PROD_BITS = SQ_BITS + SCALE_BITS;
   localparam int unsigned RAD_BITS  = PROD_BITS + 2 * FRACTION_BITS;
   localparam int unsigned ROOT_BITS = RAD_BITS / 2;
   localparam int unsigned QX_BITS   = ROOT_BITS + SLOPE_BITS;
   localparam int unsigned CMP_BITS  = ROOT_BITS + SAMPLE_BITS;

   // Pipeline moves whenever the skid register is free.
   logic                     en;
   logic                     skid_full_ff;

   // Front stage one: magnitudes and squares.
   logic [SAMPLE_BITS-1:0]   mag_x;
   logic [SAMPLE_BITS-1:0]   mag_y;
   logic [SAMPLE_BITS-1:0]   mag_z;
   asp_ctrl_type             st1_ctrl_ff;
   asp_ctrl_type             st1_ctrl_in;
   logic [SQ_BITS-1:0]       sq_x_ff;
   logic [SQ_BITS-1:0]       sq_y_ff;
   logic [SAMPLE_BITS-1:0]   az1_ff;

   // Front stage two: scaled radicand.
   logic [SQ_BITS-1:0]       sq_sum;
   logic [PROD_BITS-1:0]     sq_prod;
   asp_ctrl_type             st2_ctrl_ff;
   logic [RAD_BITS-1:0]      rad_ff;
   logic [RAD_BITS-1:0]      rad_in;
   logic [SAMPLE_BITS-1:0]   az2_ff;

   // Square root chain links.
   asp_ctrl_type             sq_ctrl [0:ROOT_BITS];
   logic [RAD_BITS-1:0]      sq_rad  [0:ROOT_BITS];
   logic [ROOT_BITS+1:0]     sq_rem  [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]     sq_root [0:ROOT_BITS];
   logic [SAMPLE_BITS-1:0]   sq_az   [0:ROOT_BITS];

   // Divider chain links.
   asp_ctrl_type             dv_ctrl [0:SLOPE_BITS];
   logic [SAMPLE_BITS:0]     dv_rem  [0:SLOPE_BITS];
   logic [SLOPE_BITS-1:0]    dv_nq   [0:SLOPE_BITS];
   logic [SAMPLE_BITS-1:0]   dv_az   [0:SLOPE_BITS];

   // Divider entry.
   logic [QX_BITS-1:0]       root_ext;
   logic [ROOT_BITS-1:0]     root_hi;
   logic                     over_range;

   // Result formatting, output register and skid register.
   logic [SLOPE_BITS-1:0]    slope_fmt;
   logic                     out_take;
   logic                     rsp_valid_ff;
   logic [SLOPE_BITS-1:0]    rsp_slope_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_inv_ff;
   logic [SLOPE_BITS-1:0]    skid_slope_ff;
   logic                     skid_sat_ff;
   logic                     skid_inv_ff;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // Magnitudes of the signed axes; the most negative code maps to 2^(N-1).
   always_comb begin
      mag_x = req_accel_x[SAMPLE_BITS-1] ? ($unsigned(~req_accel_x) + 1'b1)
                                          : $unsigned(req_accel_x);
      mag_y = req_accel_y[SAMPLE_BITS-1] ? ($unsigned(~req_accel_y) + 1'b1)
                                          : $unsigned(req_accel_y);
      mag_z = req_accel_z[SAMPLE_BITS-1] ? ($unsigned(~req_accel_z) + 1'b1)
                                          : $unsigned(req_accel_z);
      st1_ctrl_in.valid     = req_valid;
      st1_ctrl_in.invalid   = (mag_x == '0) && (mag_y == '0) && (mag_z == '0);
      st1_ctrl_in.saturated = 1'b0;
   end

   // Scale the sum of squares by 100^2 and by 4^FRACTION_BITS.
   always_comb begin
      sq_sum  = sq_x_ff + sq_y_ff;
      sq_prod = PROD_BITS'(sq_sum) * PROD_BITS'(SCALE_PCT_SQ);
      rad_in  = RAD_BITS'(sq_prod) << (2 * FRACTION_BITS);
   end

   // Front stage control words.
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ctrl_ff <= '0;
         st2_ctrl_ff <= '0;
      end else if (en) begin
         st1_ctrl_ff <= st1_ctrl_in;
         st2_ctrl_ff <= st1_ctrl_ff;
      end
   end

   // Front stage data.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff <= SQ_BITS'(mag_x) * SQ_BITS'(mag_x);
         sq_y_ff <= SQ_BITS'(mag_y) * SQ_BITS'(mag_y);
         az1_ff  <= mag_z;
         rad_ff  <= rad_in;
         az2_ff  <= az1_ff;
      end
   end

   // Square root chain: one cell per root bit.
   assign sq_ctrl[0] = st2_ctrl_ff;
   assign sq_rad[0]  = rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_az[0]   = az2_ff;

   for (genvar gi = 0; gi < ROOT_BITS; gi++) begin : g_sqrt
      asp_sqrt_cell #(
         .RAD_BITS  (RAD_BITS),
         .ROOT_BITS (ROOT_BITS),
         .AZ_BITS   (SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (sq_ctrl[gi]),
         .rad_in   (sq_rad[gi]),
         .rem_in   (sq_rem[gi]),
         .root_in  (sq_root[gi]),
         .az_in    (sq_az[gi]),
         .ctrl_out (sq_ctrl[gi+1]),
         .rad_out  (sq_rad[gi+1]),
         .rem_out  (sq_rem[gi+1]),
         .root_out (sq_root[gi+1]),
         .az_out   (sq_az[gi+1])
      );
   end

   // Divider entry: the high root bits seed the remainder. The quotient would
   // overflow the result width exactly when they already reach |z|; zero z lands here.
   always_comb begin
      root_ext   = QX_BITS'(sq_root[ROOT_BITS]);
      root_hi    = root_ext[QX_BITS-1:SLOPE_BITS];
      over_range = (CMP_BITS'(root_hi) >= CMP_BITS'(sq_az[ROOT_BITS]));
   end

   assign dv_ctrl[0] = '{valid:     sq_ctrl[ROOT_BITS].valid,
                         invalid:   sq_ctrl[ROOT_BITS].invalid,
                         saturated: over_range};
   assign dv_rem[0]  = (SAMPLE_BITS + 1)'(root_hi);
   assign dv_nq[0]   = root_ext[SLOPE_BITS-1:0];
   assign dv_az[0]   = sq_az[ROOT_BITS];

   // Divider chain: one cell per result bit.
   for (genvar gj = 0; gj < SLOPE_BITS; gj++) begin : g_div
      asp_div_cell #(
         .AZ_BITS  (SAMPLE_BITS),
         .QUO_BITS (SLOPE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (dv_ctrl[gj]),
         .rem_in   (dv_rem[gj]),
         .nq_in    (dv_nq[gj]),
         .az_in    (dv_az[gj]),
         .ctrl_out (dv_ctrl[gj+1]),
         .rem_out  (dv_rem[gj+1]),
         .nq_out   (dv_nq[gj+1]),
         .az_out   (dv_az[gj+1])
      );
   end

   // All axes zero wins over saturation; otherwise clip to full scale.
   always_comb begin
      if (dv_ctrl[SLOPE_BITS].invalid) begin
         slope_fmt = '0;
      end else if (dv_ctrl[SLOPE_BITS].saturated) begin
         slope_fmt = SLOPE_MAX;
      end else begin
         slope_fmt = dv_nq[SLOPE_BITS];
      end
   end

   assign out_take = rsp_valid_ff && !rsp_stall;

   // Output and skid control: a result leaving the chain goes to the output
   // register when it is free, otherwise to the skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (out_take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_valid_ff <= dv_ctrl[SLOPE_BITS].valid;
      end else if (dv_ctrl[SLOPE_BITS].valid) begin
         skid_full_ff <= 1'b1;
      end
   end

   // Output and skid payload.
   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (out_take) begin
            rsp_slope_ff <= skid_slope_ff;
            rsp_sat_ff   <= skid_sat_ff;
            rsp_inv_ff   <= skid_inv_ff;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_slope_ff <= slope_fmt;
         rsp_sat_ff   <= dv_ctrl[SLOPE_BITS].saturated && !dv_ctrl[SLOPE_BITS].invalid;
         rsp_inv_ff   <= dv_ctrl[SLOPE_BITS].invalid;
      end else begin
         skid_slope_ff <= slope_fmt;
         skid_sat_ff   <= dv_ctrl[SLOPE_BITS].saturated && !dv_ctrl[SLOPE_BITS].invalid;
         skid_inv_ff   <= dv_ctrl[SLOPE_BITS].invalid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slope_pct_q8 = rsp_slope_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_invalid      = rsp_inv_ff;

`ifndef SYNTHESIS
   // An all-zero sample reads as zero slope and is never flagged as clipped.
   a_invalid_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> (rsp_slope_pct_q8 == '0) && !rsp_saturated)
      else $error("invalid result carries a nonzero slope or saturation");

   // A clipped result shows full scale.
   a_sat_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_slope_pct_q8 == SLOPE_MAX))
      else $error("saturated result is not full scale");

   // The skid register only fills behind a held output beat.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid register full while output register is empty");

   // The skid register fills only when the receiver stalled a waiting beat.
   a_skid_fill_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled output beat");

   // While the skid register is full the chain holds its last result.
   a_chain_holds : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !$past(reset) && $past(skid_full_ff) |->
         $stable(dv_ctrl[SLOPE_BITS]))
      else $error("pipeline moved while the skid register was full");
`endif

endmodule : accel_slope_percent_unit
`default_nettype wire
